[sv/mtb_pkg.sv]
package mtb_pkg;

  localparam int DEF_NUM_TIMERS = 16;
  localparam int CMD_W          = 3;
  localparam int SLOT_W         = 4;
  localparam int MS_W           = 32;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   value;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] expired_slot;
    logic              last;
  } out_t;

  // Slot command broadcast from the controller to every cell.
  typedef struct packed {
    logic              we;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   value;
  } cell_cmd_t;

  // Walk token and elapsed time handed from one cell to the next.
  typedef struct packed {
    logic            tok;
    logic [MS_W-1:0] elapsed;
  } link_t;

endpackage

[sv/mtb_cell.sv]
module mtb_cell #(
  parameter int INDEX = 0,
  parameter int CMP_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mtb_pkg::cell_cmd_t cmd_in,
  input  mtb_pkg::link_t     link_in,
  output mtb_pkg::link_t     link_out,
  output logic               expire
);
  import mtb_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic [MS_W-1:0] rem_r, rem_nxt;
  logic [MS_W-1:0] reload_r, reload_nxt;
  logic            run_r, run_nxt;
  logic            regd_r, regd_nxt;
  logic            tok_r;
  logic [MS_W-1:0] elapsed_r;
  logic            match;

  assign match = cmd_in.we && (CMP_W'(cmd_in.slot) == MY_IDX);

  always_comb begin
    rem_nxt    = rem_r;
    reload_nxt = reload_r;
    run_nxt    = run_r;
    regd_nxt   = regd_r;
    expire     = 1'b0;
    if (tok_r) begin
      // The elapsed time on a walk is never zero, so saturation means expiry.
      if (regd_r && run_r) begin
        if (elapsed_r >= rem_r) begin
          rem_nxt = '0;
          run_nxt = 1'b0;
          expire  = 1'b1;
        end else begin
          rem_nxt = rem_r - elapsed_r;
        end
      end
    end else if (match) begin
      unique case (cmd_in.cmd)
        CMD_SET: begin
          rem_nxt    = cmd_in.value;
          reload_nxt = cmd_in.value;
        end
        CMD_START: begin
          rem_nxt = reload_r;
          run_nxt = 1'b1;
        end
        CMD_STOP: begin
          run_nxt = 1'b0;
        end
        CMD_REGISTER: begin
          rem_nxt    = '0;
          reload_nxt = '0;
          run_nxt    = 1'b0;
          regd_nxt   = 1'b1;
        end
        CMD_REMOVE: begin
          regd_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      reload_r <= '0;
      run_r    <= 1'b0;
      regd_r   <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      reload_r <= reload_nxt;
      run_r    <= run_nxt;
      regd_r   <= regd_nxt;
      tok_r    <= link_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= link_in.elapsed;
  end

  assign link_out.tok     = tok_r;
  assign link_out.elapsed = elapsed_r;

endmodule

[sv/multi_slot_countdown_timer_bank.sv]
// A nonzero tick is taken when start is high and busy low; busy then stays high through
// the walk and the flush, and no command is accepted until busy falls again.
// The walk token visits one slot cell per cycle; expiries leave in slot order, the
// final one marked last and sent from the flush state. Other commands and zero ticks
// leave busy low. Results are strobed by out_valid for one cycle each;
// the receiver cannot stall. Synchronous reset clears all slots and the walk.
module multi_slot_countdown_timer_bank #(
  parameter int NUM_TIMERS = mtb_pkg::DEF_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mtb_pkg::in_t  in_data,
  output logic          out_valid,
  output mtb_pkg::out_t out_data
);
  import mtb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [SLOT_W-1:0] hold_slot_r, hold_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              accept;
  logic              tick_go;
  cell_cmd_t         cell_cmd;
  link_t             chain [0:NUM_TIMERS];
  logic [NUM_TIMERS-1:0] expire_vec;
  logic              hit;

  assign accept  = start && (state_r == ST_IDLE);
  assign tick_go = accept && (in_data.cmd == CMD_TICK) && (in_data.value != '0);

  assign cell_cmd.we    = accept && (in_data.cmd != CMD_TICK);
  assign cell_cmd.cmd   = in_data.cmd;
  assign cell_cmd.slot  = in_data.slot;
  assign cell_cmd.value = in_data.value;

  assign chain[0].tok     = tick_go;
  assign chain[0].elapsed = in_data.value;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    mtb_cell #(
      .INDEX (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd_in   (cell_cmd),
      .link_in  (chain[i]),
      .link_out (chain[i+1]),
      .expire   (expire_vec[i])
    );
  end

  // Only the cell holding the token can expire, so the OR names the current slot.
  assign hit = |expire_vec;

  // An expiry is held until the next expiry or the flush, so the last mark is known when it leaves.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hold_v_nxt    = hold_v_r;
    hold_slot_nxt = hold_slot_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt    = '0;
        hold_v_nxt = 1'b0;
        if (tick_go) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (hit) begin
          hold_v_nxt    = 1'b1;
          hold_slot_nxt = SLOT_W'(cnt_r);
          if (hold_v_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt.expired_slot = hold_slot_r;
            out_nxt.last         = 1'b0;
          end
        end
        if (chain[NUM_TIMERS].tok) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt        = hold_v_r;
        out_nxt.expired_slot = hold_slot_r;
        out_nxt.last         = 1'b1;
        hold_v_nxt           = 1'b0;
        state_nxt            = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hold_slot_r <= hold_slot_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
